// ===== rtl/ucn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucn_pkg: shared types and constants for the universal character name decoder
// Defines the word types on both channels, the command word that goes from
// the parser to the emitter, and the ASCII codes that the escape uses.
// ----------------------------------------------------------------------------
package ucn_pkg;

   localparam int CP_W    = 21;
   localparam int VALUE_W = 32;
   localparam int DIGIT_W = 7;
   localparam int HOLD_N  = 8;
   localparam int HCNT_W  = 3;
   localparam int POS_W   = 4;

   localparam logic [CP_W-1:0] CH_BACKSLASH = CP_W'('h5C);
   localparam logic [CP_W-1:0] CH_SMALL_U   = CP_W'('h75);
   localparam logic [CP_W-1:0] CH_BIG_U     = CP_W'('h55);

   localparam logic [HCNT_W-1:0] SHORT_LAST = HCNT_W'(3);
   localparam logic [HCNT_W-1:0] LONG_LAST  = HCNT_W'(7);

   typedef enum logic {
      ACT_CHAR = 1'b0,
      ACT_END  = 1'b1
   } action_type;

   // What the emitter replays before the tail word.
   typedef enum logic [1:0] {
      FL_NONE   = 2'd0,
      FL_SLASH  = 2'd1,
      FL_DIGITS = 2'd2
   } flush_type;

   // The word that closes a command, if any.
   typedef enum logic [1:0] {
      TL_NONE  = 2'd0,
      TL_VALUE = 2'd1,
      TL_END   = 2'd2
   } tail_type;

   typedef struct packed {
      logic            action;
      logic [CP_W-1:0] code_point;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value_out;
      logic               is_end;
      logic               last;
   } rsp_type;

   typedef struct packed {
      flush_type                        flush;
      logic                             long_form;
      logic [HCNT_W-1:0]                count;
      logic [HOLD_N-1:0][DIGIT_W-1:0]   digits;
      tail_type                         tail;
      logic [VALUE_W-1:0]               tail_value;
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/ucn_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucn_front: escape parser
// Tracks the escape state, collects hex digits and the partial value, and
// turns each accepted word into at most one command for the emitter.
// ----------------------------------------------------------------------------
module ucn_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire ucn_pkg::req_type req_item,
   output logic                  cmd_push,
   output ucn_pkg::cmd_type      cmd
);
   import ucn_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SLASH  = 2'd1,
      ST_DIGITS = 2'd2
   } state_type;

   state_type                      state_ff, state_in;
   logic                           long_ff, long_in;
   logic [HCNT_W-1:0]              count_ff, count_in;
   logic [VALUE_W-1:0]             partial_ff, partial_in;
   logic [HOLD_N-1:0][DIGIT_W-1:0] digits_ff, digits_in;

   logic [CP_W-1:0] ch;
   logic            ch_slash;
   logic            ch_hex;
   logic [3:0]      ch_nib;
   logic            escape_done;

   always_comb begin
      ch       = req_item.code_point;
      ch_slash = (ch == CH_BACKSLASH);
      ch_hex   = 1'b1;
      ch_nib   = 4'd0;
      if (ch >= CP_W'('h30) && ch <= CP_W'('h39)) begin
         ch_nib = 4'(ch - CP_W'('h30));
      end else if (ch >= CP_W'('h41) && ch <= CP_W'('h46)) begin
         ch_nib = 4'(ch - CP_W'('h37));
      end else if (ch >= CP_W'('h61) && ch <= CP_W'('h66)) begin
         ch_nib = 4'(ch - CP_W'('h57));
      end else begin
         ch_hex = 1'b0;
      end
      escape_done = (count_ff == (long_ff ? LONG_LAST : SHORT_LAST));
   end

   always_comb begin
      state_in   = state_ff;
      long_in    = long_ff;
      count_in   = count_ff;
      partial_in = partial_ff;
      digits_in  = digits_ff;

      cmd_push       = 1'b0;
      cmd.flush      = FL_NONE;
      cmd.long_form  = long_ff;
      cmd.count      = count_ff;
      cmd.digits     = digits_ff;
      cmd.tail       = TL_NONE;
      cmd.tail_value = VALUE_W'(ch);

      if (accept) begin
         if (req_item.action == ACT_END) begin
            // flush whatever is held, then mark the end
            cmd_push   = 1'b1;
            cmd.tail   = TL_END;
            cmd.flush  = (state_ff == ST_SLASH)  ? FL_SLASH  :
                         (state_ff == ST_DIGITS) ? FL_DIGITS : FL_NONE;
            state_in   = ST_IDLE;
            long_in    = 1'b0;
            count_in   = '0;
            partial_in = '0;
         end else begin
            unique case (state_ff)
               ST_SLASH: begin
                  if (ch == CH_SMALL_U || ch == CH_BIG_U) begin
                     state_in   = ST_DIGITS;
                     long_in    = (ch == CH_BIG_U);
                     count_in   = '0;
                     partial_in = '0;
                  end else begin
                     cmd_push  = 1'b1;
                     cmd.flush = FL_SLASH;
                     cmd.tail  = ch_slash ? TL_NONE : TL_VALUE;
                     state_in  = ch_slash ? ST_SLASH : ST_IDLE;
                  end
               end
               ST_DIGITS: begin
                  if (ch_hex) begin
                     digits_in[count_ff] = ch[DIGIT_W-1:0];
                     partial_in          = {partial_ff[VALUE_W-5:0], ch_nib};
                     if (escape_done) begin
                        cmd_push       = 1'b1;
                        cmd.tail       = TL_VALUE;
                        cmd.tail_value = partial_in;
                        state_in       = ST_IDLE;
                        long_in        = 1'b0;
                        count_in       = '0;
                        partial_in     = '0;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end else begin
                     // replay backslash, u/U and the digits, then this word unless it is a backslash
                     cmd_push   = 1'b1;
                     cmd.flush  = FL_DIGITS;
                     cmd.tail   = ch_slash ? TL_NONE : TL_VALUE;
                     state_in   = ch_slash ? ST_SLASH : ST_IDLE;
                     long_in    = 1'b0;
                     count_in   = '0;
                     partial_in = '0;
                  end
               end
               default: begin
                  if (ch_slash) begin
                     state_in = ST_SLASH;
                  end else begin
                     cmd_push = 1'b1;
                     cmd.tail = TL_VALUE;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         long_ff    <= 1'b0;
         count_ff   <= '0;
         partial_ff <= '0;
      end else begin
         state_ff   <= state_in;
         long_ff    <= long_in;
         count_ff   <= count_in;
         partial_ff <= partial_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
   end

endmodule
`default_nettype wire

// ===== rtl/ucn_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucn_queue: command queue
// Small circular buffer that decouples the parser from the emitter.
// ----------------------------------------------------------------------------
module ucn_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ucn_pkg::cmd_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output ucn_pkg::cmd_type      pop_data,
   output logic                  empty
);
   import ucn_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type            store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   always_comb begin
      full     = (count_ff == CNT_FULL);
      empty    = (count_ff == '0);
      pop_data = store_ff[rd_ptr_ff];
      do_push  = push && !full;
      do_pop   = pop && !empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ucn_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ucn_back: result emitter
// Expands one command into its result words, one per cycle while the output
// stage is empty or being popped, into a registered output stage.
// ----------------------------------------------------------------------------
module ucn_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ucn_pkg::cmd_type cmd,
   input  wire logic             cmd_empty,
   output logic                  cmd_pop,
   output ucn_pkg::rsp_type      rsp_item,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop
);
   import ucn_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   rsp_type          out_ff, out_in;
   logic             valid_ff, valid_in;

   logic             advance;
   logic [POS_W-1:0] flush_len;
   logic [POS_W-1:0] total_len;
   logic [POS_W-1:0] digit_pos;
   rsp_type          word;

   always_comb begin
      case (cmd.flush)
         FL_SLASH:  flush_len = POS_W'(1);
         FL_DIGITS: flush_len = POS_W'(2) + POS_W'(cmd.count);
         default:   flush_len = '0;
      endcase
      total_len = flush_len + ((cmd.tail == TL_NONE) ? POS_W'(0) : POS_W'(1));
      digit_pos = pos_ff - POS_W'(2);

      word.value_out = '0;
      word.is_end    = 1'b0;
      word.last      = (pos_ff + 1'b1 == total_len);
      if (pos_ff < flush_len) begin
         if (pos_ff == '0) begin
            word.value_out = VALUE_W'(CH_BACKSLASH);
         end else if (pos_ff == POS_W'(1)) begin
            word.value_out = VALUE_W'(cmd.long_form ? CH_BIG_U : CH_SMALL_U);
         end else begin
            word.value_out = VALUE_W'(cmd.digits[digit_pos[HCNT_W-1:0]]);
         end
      end else if (cmd.tail == TL_END) begin
         word.is_end = 1'b1;
      end else begin
         word.value_out = cmd.tail_value;
      end

      // refill the output stage when it is empty or being taken
      advance  = !valid_ff || rsp_pop;
      cmd_pop  = 1'b0;
      pos_in   = pos_ff;
      out_in   = out_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = !cmd_empty;
         if (!cmd_empty) begin
            out_in = word;
            if (word.last) begin
               cmd_pop = 1'b1;
               pos_in  = '0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end

      rsp_item  = out_ff;
      rsp_empty = !valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule
`default_nettype wire

// ===== rtl/universal_char_name_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// universal_char_name_decoder: replace \uXXXX and \UXXXXXXXX escapes
// Input side is a queue write port: a word (code point or end of input) is
// taken when req_push is high and req_full is low. Result side is a queue
// read port: while rsp_empty is low the oldest result is on rsp_item, and it
// is taken when rsp_pop is high.
// A parser accepts one word per cycle while req_full is low and posts at most
// one command into a short command queue; the emitter expands each command into
// its result words at one word per cycle, while the output register is empty or
// being popped, into that register. A word that yields a result passes through
// the command queue and then the output register before it reaches rsp_item.
// Throughput: one word per cycle for plain text while the receiver pops; a
// command that replays a broken escape emits one result word at a time (up to
// ten words), and req_full rises once the command queue fills behind it.
// Reset clears the parser state, the queue and the output valid flag; held
// digits need no clearing since only written entries are ever replayed.
// When the receiver stalls, the output word holds, the emitter stops, and
// the queue fills until req_full stops the sender; nothing is dropped.
// ----------------------------------------------------------------------------
module universal_char_name_decoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire ucn_pkg::req_type req_item,
   output logic                  req_full,
   input  wire logic             rsp_pop,
   output ucn_pkg::rsp_type      rsp_item,
   output logic                  rsp_empty
);
   import ucn_pkg::*;

   logic    accept;
   logic    cmd_push;
   cmd_type cmd_wr;
   cmd_type cmd_rd;
   logic    cmd_full;
   logic    cmd_empty;
   logic    cmd_pop;

   // hold input while the command queue has no room
   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   ucn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .cmd_push (cmd_push),
      .cmd      (cmd_wr)
   );

   ucn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd),
      .empty     (cmd_empty)
   );

   ucn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule
`default_nettype wire

// ===== tb/sv/universal_char_name_decoder_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// universal_char_name_decoder_tb: self-checking bench for the escape decoder
// Drives a stream of code points and end-of-input words through the push/full
// port. A scoreboard predicts the decoded stream and checks every word popped
// from the result port. The stimulus is a short directed run, then random
// escapes, broken escapes, plain characters and end markers. The sender works
// in bursts and the receiver stalls, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module universal_char_name_decoder_tb;
   import ucn_pkg::*;

   // Scoreboard: tracks the escape parser state and queues the expected words.
   class ucn_scoreboard;
      typedef enum logic [1:0] {
         PH_IDLE   = 2'd0,
         PH_SLASH  = 2'd1,
         PH_DIGITS = 2'd2
      } esc_phase_type;

      localparam int unsigned SHORT_DIGITS = 4;
      localparam int unsigned LONG_DIGITS  = 8;

      esc_phase_type phase;
      logic          long_form;
      int unsigned   digit_count;
      logic [6:0]    held_digits[8];
      logic [31:0]   partial_value;
      rsp_type       expected_words[$];
      rsp_type       step_words[$];
      int unsigned   errors;

      function new();
         clear_hold();
         errors = 0;
      endfunction

      function void clear_hold();
         phase         = PH_IDLE;
         long_form     = 1'b0;
         digit_count   = 0;
         partial_value = '0;
      endfunction

      function void add_word(logic [31:0] value, logic end_flag);
         rsp_type w;
         w.value_out = value;
         w.is_end    = end_flag;
         w.last      = 1'b0;
         step_words.insert(step_words.size(), w);
      endfunction

      // Replay whatever the escape holds, unchanged, then drop the hold.
      function void flush_hold();
         if (phase != PH_IDLE) add_word(32'(CH_BACKSLASH), 1'b0);
         if (phase == PH_DIGITS) begin
            add_word(long_form ? 32'(CH_BIG_U) : 32'(CH_SMALL_U), 1'b0);
            for (int i = 0; i < digit_count; i++) add_word(32'(held_digits[i]), 1'b0);
         end
         clear_hold();
      endfunction

      function int hex_digit(logic [CP_W-1:0] c);
         if (c >= 21'h30 && c <= 21'h39) return int'(c - 21'h30);
         if (c >= 21'h41 && c <= 21'h46) return int'(c - 21'h41) + 10;
         if (c >= 21'h61 && c <= 21'h66) return int'(c - 21'h61) + 10;
         return -1;
      endfunction

      function void plain_char(logic [CP_W-1:0] c);
         if (c == CH_BACKSLASH) phase = PH_SLASH;
         else add_word(32'(c), 1'b0);
      endfunction

      // Note one accepted input word and queue the words it must produce.
      function void note_word(req_type w);
         int              h;
         logic [CP_W-1:0] c;
         rsp_type         tail;
         step_words.delete();
         c = w.code_point;
         if (w.action == ACT_END) begin
            flush_hold();
            add_word('0, 1'b1);
         end else begin
            case (phase)
               PH_SLASH: begin
                  if (c == CH_SMALL_U || c == CH_BIG_U) begin
                     phase         = PH_DIGITS;
                     long_form     = (c == CH_BIG_U);
                     digit_count   = 0;
                     partial_value = '0;
                  end else begin
                     flush_hold();
                     plain_char(c);
                  end
               end
               PH_DIGITS: begin
                  h = hex_digit(c);
                  if (h >= 0) begin
                     held_digits[digit_count] = c[6:0];
                     digit_count++;
                     partial_value = {partial_value[27:0], 4'(h)};
                     if (digit_count >= (long_form ? LONG_DIGITS : SHORT_DIGITS)) begin
                        add_word(partial_value, 1'b0);
                        clear_hold();
                     end
                  end else begin
                     flush_hold();
                     plain_char(c);
                  end
               end
               default: plain_char(c);
            endcase
         end
         if (step_words.size() > 0) begin
            tail      = step_words.pop_back();
            tail.last = 1'b1;
            step_words.insert(step_words.size(), tail);
         end
         foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
      endfunction

      // Check one popped word against the oldest expected word.
      function void check_word(rsp_type got);
         rsp_type want;
         if (expected_words.size() == 0) begin
            $error("unexpected word: value_out %h, is_end %b, last %b",
                   got.value_out, got.is_end, got.last);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         if (got.value_out !== want.value_out) begin
            $error("value_out: expected %h, actual %h", want.value_out, got.value_out);
            errors++;
         end
         if (got.is_end !== want.is_end) begin
            $error("is_end: expected %b, actual %b", want.is_end, got.is_end);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   localparam int unsigned RANDOM_WORDS  = 460;
   localparam int unsigned HOLD_START    = 150;
   localparam int unsigned HOLD_CYCLES   = 250;
   localparam int unsigned DRAIN_CYCLES  = 12;
   localparam int unsigned RUN_LIMIT     = 3_200_000;
   localparam string       HEX_CHARS     = "0123456789abcdefABCDEF";
   localparam string       BREAK_CHARS   = "/:@G`g\\uU";

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   req_type req_item = '0;
   logic    req_full;
   logic    rsp_pop  = 1'b0;
   rsp_type rsp_item;
   logic    rsp_empty;

   ucn_scoreboard sb = new();
   int unsigned   burst_left  = 0;
   int unsigned   words_sent  = 0;

   universal_char_name_decoder i_dut (
      .clock,
      .reset,
      .req_push,
      .req_item,
      .req_full,
      .rsp_pop,
      .rsp_item,
      .rsp_empty
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Sample both handshakes at the rising edge; note inputs before checking.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) sb.note_word(req_item);
         if (rsp_pop && !rsp_empty) sb.check_word(rsp_item);
      end
   end

   // Offer one word at the falling edge and hold it until the block takes it.
   // Close a burst with a random gap once its length runs out.
   task automatic send_word(input action_type act, input logic [CP_W-1:0] cp);
      req_type w;
      w.action     = act;
      w.code_point = cp;
      req_item <= w;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      words_sent++;
      if (burst_left == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 60);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(ACT_CHAR, CP_W'(s[i]));
   endtask

   function automatic logic [CP_W-1:0] rand_hex_digit();
      return CP_W'(HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)]);
   endfunction

   // Pick a character that breaks an escape: near-miss hex, backslash, u/U,
   // any code point, or one whose low bits look like a hex digit.
   function automatic logic [CP_W-1:0] rand_breaker();
      case ($urandom_range(0, 3))
         0, 1:    return CP_W'(BREAK_CHARS[$urandom_range(0, BREAK_CHARS.len() - 1)]);
         2:       return CP_W'($urandom_range(0, 'h10FFFF));
         default: return CP_W'(($urandom_range(1, 'h10F0) << 8) | rand_hex_digit());
      endcase
   endfunction

   function automatic logic [CP_W-1:0] rand_plain();
      case ($urandom_range(0, 5))
         0, 1:    return CP_W'($urandom_range('h20, 'h7E));
         2:       return CP_W'($urandom_range(0, 'h10FFFF));
         3:       return rand_hex_digit();
         4:       return $urandom_range(0, 1) ? CP_W'('h10FFFF) : CP_W'(0);
         default: return rand_breaker();
      endcase
   endfunction

   // Main stimulus: reset, directed words, random stream, drain, verdict.
   initial begin
      int unsigned r;
      int unsigned need;
      int unsigned base;
      logic        long_esc;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Extremes of the code point, a short and a long escape in mixed case,
      // a backslash broken by a second backslash that starts a new escape,
      // an escape broken among its digits, and an end that flushes a backslash.
      send_word(ACT_CHAR, CP_W'('h41));
      send_word(ACT_CHAR, CP_W'('h10FFFF));
      send_word(ACT_CHAR, CP_W'(0));
      send_text("\\u00e9");
      send_text("\\UfFfF0a9B");
      send_text("\\\\U12g");
      send_text("\\");
      send_word(ACT_END, CP_W'('h10FFFF));

      // Random part: a mix of well-formed escapes with random digits (the largest
      // share), broken escapes, plain text and end markers.
      base = words_sent;
      while (words_sent < base + RANDOM_WORDS) begin
         r        = $urandom_range(0, 99);
         long_esc = 1'($urandom_range(0, 1));
         need     = long_esc ? 8 : 4;
         if (r < 45) begin
            send_word(ACT_CHAR, CH_BACKSLASH);
            send_word(ACT_CHAR, long_esc ? CH_BIG_U : CH_SMALL_U);
            repeat (need) send_word(ACT_CHAR, rand_hex_digit());
         end else if (r < 65) begin
            send_word(ACT_CHAR, CH_BACKSLASH);
            if ($urandom_range(0, 3) != 0) begin
               send_word(ACT_CHAR, long_esc ? CH_BIG_U : CH_SMALL_U);
               repeat ($urandom_range(0, need - 1)) send_word(ACT_CHAR, rand_hex_digit());
            end
            if ($urandom_range(0, 4) == 0) send_word(ACT_END, CP_W'($urandom_range(0, 'h10FFFF)));
            else send_word(ACT_CHAR, rand_breaker());
         end else if (r < 92) begin
            send_word(ACT_CHAR, rand_plain());
         end else begin
            send_word(ACT_END, CP_W'($urandom_range(0, 'h10FFFF)));
         end
      end
      // Flush anything still held.
      send_word(ACT_END, CP_W'(0));
      req_push <= 1'b0;

      // Drain the expected words, then keep watching for strays.
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Receiver: change pop at the falling edge on a segment pattern of its own,
   // and hold off for a long stretch once so the block fills and pushes back.
   initial begin
      int unsigned cyc;
      int unsigned seg_left;
      int unsigned mode;
      cyc      = 0;
      seg_left = 0;
      mode     = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         cyc++;
         if (seg_left == 0) begin
            mode     = $urandom_range(0, 3);
            seg_left = $urandom_range(4, 60);
         end
         seg_left--;
         if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
            rsp_pop <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_pop <= 1'b1;
               1:       rsp_pop <= 1'($urandom_range(0, 1));
               2:       rsp_pop <= ($urandom_range(0, 3) == 0);
               default: rsp_pop <= cyc[0];
            endcase
         end
      end
   end

   // Watchdog: end a hung run.
   initial begin
      #RUN_LIMIT;
      $display("TEST FAILED");
      $finish;
   end

endmodule
`default_nettype wire
